// ===== design/mao_pkg.sv =====
// Shared types, constants and helpers for the motor ADC offset and low-pass block.
package mao_pkg;

    localparam int RAW_W       = 12;
    localparam int DATA_W      = 32;
    localparam int GAIN_W      = 32;
    localparam int COEF_W      = 16;
    localparam int SUM_W       = 16;
    localparam int CAL_CNT_W   = 4;
    localparam int PROD_W      = 49;
    localparam int ACC_W       = 51;
    localparam int FRAC_BITS   = 15;
    localparam int ROUND_HALF  = 16384;
    localparam int RECIP_SHIFT = 31;
    localparam int NUM_CH      = 6;
    localparam int CH_W        = 3;
    localparam int NUM_GRP     = 3;
    localparam int GRP_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int STEP_W      = 4;

    localparam logic MODE_CAL = 1'b1;

    // filter channel order
    localparam logic [CH_W-1:0] CH_U    = 3'd0;
    localparam logic [CH_W-1:0] CH_V    = 3'd1;
    localparam logic [CH_W-1:0] CH_W_PH = 3'd2;
    localparam logic [CH_W-1:0] CH_VBUS = 3'd3;
    localparam logic [CH_W-1:0] CH_TEMP = 3'd4;
    localparam logic [CH_W-1:0] CH_REF  = 3'd5;

    // coefficient groups
    localparam logic [GRP_W-1:0] GRP_RUN  = 2'd0;
    localparam logic [GRP_W-1:0] GRP_SLOW = 2'd1;
    localparam logic [GRP_W-1:0] GRP_REF  = 2'd2;

    // run sequence steps
    localparam logic [STEP_W-1:0] STEP_MUL_U      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_W      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_VBUS   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_FIRST_FILT = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FIRST_WB   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LAST_RUN   = 4'd15;

    // calibration sequence steps
    localparam logic [STEP_W-1:0] CAL_STEP_ACC   = 4'd0;
    localparam logic [STEP_W-1:0] CAL_STEP_DIV_U = 4'd1;
    localparam logic [STEP_W-1:0] CAL_STEP_DIV_W = 4'd2;
    localparam logic [STEP_W-1:0] CAL_STEP_STORE = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUR_GAIN  = 3'd0,
        CFG_VBUS_GAIN = 3'd1,
        CFG_RUN_NEW   = 3'd2,
        CFG_RUN_OLD   = 3'd3,
        CFG_SLOW_NEW  = 3'd4,
        CFG_SLOW_OLD  = 3'd5,
        CFG_REF_NEW   = 3'd6,
        CFG_REF_OLD   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_CAL  = 2'd1,
        BK_RUN  = 2'd2,
        BK_DONE = 2'd3
    } t_back_state;

    typedef struct packed {
        logic             is_cal;
        logic [RAW_W-1:0] cur_u_raw;
        logic [RAW_W-1:0] temp_raw;
        logic [RAW_W-1:0] vbus_raw;
        logic [RAW_W-1:0] cur_w_raw;
        logic [RAW_W-1:0] ref_raw;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic [GAIN_W-1:0]                    cur_gain;
        logic [GAIN_W-1:0]                    vbus_gain;
        logic [NUM_GRP-1:0][COEF_W-1:0]       coef_new;
        logic [NUM_GRP-1:0][COEF_W-1:0]       coef_old;
    } t_cfg;

    function automatic logic [GRP_W-1:0] coef_grp(input logic [CH_W-1:0] ch);
        logic [GRP_W-1:0] grp;
        case (ch)
            CH_U, CH_V, CH_W_PH: grp = GRP_RUN;
            CH_VBUS, CH_TEMP:    grp = GRP_SLOW;
            default:             grp = GRP_REF;
        endcase
        return grp;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
            res = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== design/mao_intf.sv =====
// Handshake channel interfaces: sample input, filtered result and register write.
interface mao_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [mao_pkg::RAW_W-1:0]  cur_u_raw;
    logic [mao_pkg::RAW_W-1:0]  temp_raw;
    logic [mao_pkg::RAW_W-1:0]  vbus_raw;
    logic [mao_pkg::RAW_W-1:0]  cur_w_raw;
    logic [mao_pkg::RAW_W-1:0]  ref_raw;
    modport source(output valid, mode, cur_u_raw, temp_raw, vbus_raw, cur_w_raw, ref_raw,
                   input ready);
    modport sink(input valid, mode, cur_u_raw, temp_raw, vbus_raw, cur_w_raw, ref_raw,
                 output ready);
endinterface

interface mao_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mao_pkg::DATA_W-1:0] cur_u_out;
    logic signed [mao_pkg::DATA_W-1:0] cur_v_out;
    logic signed [mao_pkg::DATA_W-1:0] cur_w_out;
    logic signed [mao_pkg::DATA_W-1:0] vbus_out;
    logic signed [mao_pkg::DATA_W-1:0] temp_out;
    logic signed [mao_pkg::DATA_W-1:0] ref_out;
    logic                              offsets_ready;
    modport source(output valid, cur_u_out, cur_v_out, cur_w_out, vbus_out, temp_out, ref_out,
                   offsets_ready, input ready);
    modport sink(input valid, cur_u_out, cur_v_out, cur_w_out, vbus_out, temp_out, ref_out,
                 offsets_ready, output ready);
endinterface

interface mao_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mao_pkg::CFG_IDX_W-1:0] index;
    logic [mao_pkg::DATA_W-1:0]    data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== design/mao_front.sv =====
// Front end: accepts sample items, tags calibration vs run, and queues them.
module mao_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mao_in_if.sink           i_in,
    input  logic             i_pop,
    output mao_pkg::t_q_head o_head
);

    mao_pkg::t_item                   r_mem [mao_pkg::QDEPTH];
    logic [mao_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [mao_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [mao_pkg::QPTR_W:0]         r_count;
    logic                             w_push;
    logic                             w_pop;
    mao_pkg::t_item                   w_item;

    assign i_in.ready = (r_count != (mao_pkg::QPTR_W+1)'(mao_pkg::QDEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != '0);

    always_comb begin
        w_item.is_cal    = (i_in.mode == mao_pkg::MODE_CAL);
        w_item.cur_u_raw = i_in.cur_u_raw;
        w_item.temp_raw  = i_in.temp_raw;
        w_item.vbus_raw  = i_in.vbus_raw;
        w_item.cur_w_raw = i_in.cur_w_raw;
        w_item.ref_raw   = i_in.ref_raw;
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == mao_pkg::QPTR_W'(mao_pkg::QDEPTH - 1)) ? '0
                          : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == mao_pkg::QPTR_W'(mao_pkg::QDEPTH - 1)) ? '0
                          : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/mao_back.sv =====
// Back end: calibration accumulate/divide and the six-channel filter sequence on one multiplier.
module mao_back #(
    parameter int CAL_SAMPLES = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mao_pkg::t_q_head i_head,
    output logic             o_pop,
    input  mao_pkg::t_cfg    i_cfg,
    mao_out_if.source        o_res
);

    localparam int CntW = mao_pkg::CAL_CNT_W;
    // reciprocal for the divide by the round length: floor(x / N) = (x * M) >> 31
    localparam logic [mao_pkg::GAIN_W:0] CalRecip =
        (mao_pkg::GAIN_W+1)'((64'd1 << mao_pkg::RECIP_SHIFT) / CAL_SAMPLES + 64'd1);
    localparam logic [CntW:0] CalLast = (CntW+1)'(CAL_SAMPLES);

    mao_pkg::t_back_state r_state;
    mao_pkg::t_back_state n_state;

    logic [mao_pkg::STEP_W-1:0]           r_step;
    mao_pkg::t_item                       r_cur;
    logic [mao_pkg::RAW_W-1:0]            r_off_u;
    logic [mao_pkg::RAW_W-1:0]            r_off_w;
    logic [mao_pkg::SUM_W-1:0]            r_sum_u;
    logic [mao_pkg::SUM_W-1:0]            r_sum_w;
    logic [CntW-1:0]                      r_cnt;
    logic                                 r_ready_flag;
    logic signed [mao_pkg::PROD_W-1:0]    r_prod;
    logic signed [mao_pkg::PROD_W-1:0]    r_pu;
    logic signed [mao_pkg::PROD_W-1:0]    r_pw;
    logic signed [mao_pkg::ACC_W-1:0]     r_acc;
    logic signed [mao_pkg::DATA_W-1:0]    r_xu;
    logic signed [mao_pkg::DATA_W-1:0]    r_xv;
    logic signed [mao_pkg::DATA_W-1:0]    r_xw;
    logic signed [mao_pkg::DATA_W-1:0]    r_xvb;
    logic signed [mao_pkg::DATA_W-1:0]    r_y [mao_pkg::NUM_CH];
    logic                                 r_out_valid;
    logic signed [mao_pkg::DATA_W-1:0]    r_out_y [mao_pkg::NUM_CH];
    logic                                 r_out_rdy;

    logic [mao_pkg::STEP_W-1:0]           w_step_off;
    logic [mao_pkg::CH_W-1:0]             w_ch;
    logic [mao_pkg::CH_W-1:0]             w_wr_ch;
    logic [mao_pkg::GRP_W-1:0]            w_grp;
    logic signed [mao_pkg::RAW_W:0]       w_du;
    logic signed [mao_pkg::RAW_W:0]       w_dw;
    logic signed [mao_pkg::DATA_W-1:0]    w_x_sel;
    logic signed [mao_pkg::GAIN_W:0]      w_op_a;
    logic signed [mao_pkg::DATA_W-1:0]    w_op_b;
    logic signed [mao_pkg::GAIN_W+mao_pkg::DATA_W:0] w_mul;
    logic [mao_pkg::SUM_W-1:0]            w_sum_u_n;
    logic [mao_pkg::SUM_W-1:0]            w_sum_w_n;
    logic                                 w_cal_done;
    logic signed [mao_pkg::ACC_W-1:0]     w_v_sum;
    logic signed [mao_pkg::ACC_W-1:0]     w_filt_sum;
    logic signed [mao_pkg::ACC_W-1:0]     w_filt_shift;
    logic                                 w_load;
    logic                                 w_wb;

    assign w_step_off = r_step - mao_pkg::STEP_FIRST_FILT;
    assign w_ch       = w_step_off[mao_pkg::STEP_W-1:1];
    assign w_wr_ch    = w_ch - 1'b1;
    assign w_grp      = mao_pkg::coef_grp(w_ch);

    assign w_du = $signed({1'b0, r_cur.cur_u_raw}) - $signed({1'b0, r_off_u});
    assign w_dw = $signed({1'b0, r_cur.cur_w_raw}) - $signed({1'b0, r_off_w});

    assign w_sum_u_n  = r_sum_u + mao_pkg::SUM_W'(r_cur.cur_u_raw);
    assign w_sum_w_n  = r_sum_w + mao_pkg::SUM_W'(r_cur.cur_w_raw);
    assign w_cal_done = ({1'b0, r_cnt} + 1'b1) >= CalLast;

    assign w_v_sum      = -mao_pkg::ACC_W'(r_pu) - mao_pkg::ACC_W'(r_pw);
    assign w_filt_sum   = r_acc + mao_pkg::ACC_W'(r_prod);
    assign w_filt_shift = w_filt_sum >>> mao_pkg::FRAC_BITS;

    assign w_wb = (r_state == mao_pkg::BK_RUN) && (r_step >= mao_pkg::STEP_FIRST_WB)
               && r_step[0];

    always_comb begin
        case (w_ch)
            mao_pkg::CH_U:    w_x_sel = r_xu;
            mao_pkg::CH_V:    w_x_sel = r_xv;
            mao_pkg::CH_W_PH: w_x_sel = r_xw;
            mao_pkg::CH_VBUS: w_x_sel = r_xvb;
            mao_pkg::CH_TEMP: w_x_sel = $signed({4'b0, r_cur.temp_raw, 16'h0});
            mao_pkg::CH_REF:  w_x_sel = $signed({4'b0, r_cur.ref_raw, 16'h0});
            default:          w_x_sel = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            mao_pkg::BK_RUN: begin
                if (r_step == mao_pkg::STEP_MUL_U) begin
                    w_op_a = $signed({1'b0, i_cfg.cur_gain});
                    w_op_b = mao_pkg::DATA_W'(w_du);
                end else if (r_step == mao_pkg::STEP_MUL_W) begin
                    w_op_a = $signed({1'b0, i_cfg.cur_gain});
                    w_op_b = mao_pkg::DATA_W'(w_dw);
                end else if (r_step == mao_pkg::STEP_MUL_VBUS) begin
                    w_op_a = $signed({1'b0, i_cfg.vbus_gain});
                    w_op_b = $signed(mao_pkg::DATA_W'(r_cur.vbus_raw));
                end else if (r_step[0]) begin
                    w_op_a = $signed(mao_pkg::GAIN_W'(i_cfg.coef_new[w_grp]));
                    w_op_b = w_x_sel;
                end else if (r_step != mao_pkg::STEP_LAST_RUN) begin
                    w_op_a = $signed(mao_pkg::GAIN_W'(i_cfg.coef_old[w_grp]));
                    w_op_b = r_y[w_ch];
                end
            end
            mao_pkg::BK_CAL: begin
                if (r_step == mao_pkg::CAL_STEP_DIV_U) begin
                    w_op_a = $signed(CalRecip);
                    w_op_b = $signed(mao_pkg::DATA_W'(r_sum_u));
                end else if (r_step == mao_pkg::CAL_STEP_DIV_W) begin
                    w_op_a = $signed(CalRecip);
                    w_op_b = $signed(mao_pkg::DATA_W'(r_sum_w));
                end
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_mul = w_op_a * w_op_b;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            mao_pkg::BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = i_head.item.is_cal ? mao_pkg::BK_CAL : mao_pkg::BK_RUN;
                end
            end
            mao_pkg::BK_CAL: begin
                if ((r_step == mao_pkg::CAL_STEP_ACC && !w_cal_done)
                    || r_step == mao_pkg::CAL_STEP_STORE) begin
                    n_state = mao_pkg::BK_DONE;
                end
            end
            mao_pkg::BK_RUN: begin
                if (r_step == mao_pkg::STEP_LAST_RUN) begin
                    n_state = mao_pkg::BK_DONE;
                end
            end
            mao_pkg::BK_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    w_load  = 1'b1;
                    n_state = mao_pkg::BK_IDLE;
                end
            end
            default: n_state = mao_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mao_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // block state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= '0;
            r_off_u      <= '0;
            r_off_w      <= '0;
            r_sum_u      <= '0;
            r_sum_w      <= '0;
            r_cnt        <= '0;
            r_ready_flag <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_rdy    <= 1'b0;
            for (int i = 0; i < mao_pkg::NUM_CH; i++) begin
                r_y[i] <= '0;
            end
        end else begin
            r_step <= (r_state == mao_pkg::BK_IDLE) ? '0 : r_step + 1'b1;
            if (r_state == mao_pkg::BK_CAL) begin
                case (r_step)
                    mao_pkg::CAL_STEP_ACC: begin
                        r_sum_u <= w_sum_u_n;
                        r_sum_w <= w_sum_w_n;
                        if (!w_cal_done) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    mao_pkg::CAL_STEP_DIV_W: begin
                        r_off_u <= r_prod[mao_pkg::RECIP_SHIFT +: mao_pkg::RAW_W];
                    end
                    mao_pkg::CAL_STEP_STORE: begin
                        r_off_w      <= r_prod[mao_pkg::RECIP_SHIFT +: mao_pkg::RAW_W];
                        r_sum_u      <= '0;
                        r_sum_w      <= '0;
                        r_cnt        <= '0;
                        r_ready_flag <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_wb) begin
                r_y[w_wr_ch] <= mao_pkg::sat32(w_filt_shift);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_rdy   <= r_ready_flag;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        r_prod <= mao_pkg::PROD_W'(w_mul);
        if (o_pop) begin
            r_cur <= i_head.item;
        end
        if (r_state == mao_pkg::BK_RUN) begin
            if (r_step == mao_pkg::STEP_MUL_W) begin
                r_pu <= r_prod;
            end else if (r_step == mao_pkg::STEP_MUL_VBUS) begin
                r_pw <= r_prod;
                r_xu <= mao_pkg::sat32(mao_pkg::ACC_W'(r_pu));
            end else if (r_step == mao_pkg::STEP_FIRST_FILT) begin
                r_xvb <= mao_pkg::sat32(mao_pkg::ACC_W'(r_prod));
                r_xw  <= mao_pkg::sat32(mao_pkg::ACC_W'(r_pw));
                r_xv  <= mao_pkg::sat32(w_v_sum);
            end else if (!r_step[0]) begin
                // hold a*x plus the rounding half for the b*y step
                r_acc <= mao_pkg::ACC_W'(r_prod) + mao_pkg::ACC_W'(mao_pkg::ROUND_HALF);
            end
        end
        if (w_load) begin
            r_out_y <= r_y;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.cur_u_out     = r_out_y[mao_pkg::CH_U];
    assign o_res.cur_v_out     = r_out_y[mao_pkg::CH_V];
    assign o_res.cur_w_out     = r_out_y[mao_pkg::CH_W_PH];
    assign o_res.vbus_out      = r_out_y[mao_pkg::CH_VBUS];
    assign o_res.temp_out      = r_out_y[mao_pkg::CH_TEMP];
    assign o_res.ref_out       = r_out_y[mao_pkg::CH_REF];
    assign o_res.offsets_ready = r_out_rdy;

endmodule

// ===== design/motor_adc_offset_and_lowpass_core.sv =====
// Top level: register file, sample queue front end and filter back end.
// Each item is one set of ADC readings and gives one result: the six filter outputs and
// the offsets-ready flag. A run item is picked from the two-entry input queue, runs
// sixteen steps on the single shared 33x32 multiplier (two current products, the bus
// voltage product, then new-sample and old-output products for each of the six filters),
// and is then handed to the output register. A calibration item adds its current
// readings to the round sums; the item that completes a round also divides them by
// CAL_SAMPLES, two reciprocal multiplies on the same unit. While it has room, the queue
// keeps taking items while the back end works or a result waits in the output register.
// Register writes are taken at once; write them only while the block is idle.
module motor_adc_offset_and_lowpass_core #(
    parameter int CAL_SAMPLES = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mao_in_if.sink    i_in,
    mao_out_if.source o_res,
    mao_cfg_if.sink   i_cfg
);

    mao_pkg::t_cfg    r_cfg;
    mao_pkg::t_q_head w_head;
    logic             w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cur_gain  <= 32'h0001_0000;
            r_cfg.vbus_gain <= 32'h0001_0000;
            r_cfg.coef_new  <= {mao_pkg::NUM_GRP{16'h8000}};
            r_cfg.coef_old  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (mao_pkg::t_cfg_idx'(i_cfg.index))
                mao_pkg::CFG_CUR_GAIN:  r_cfg.cur_gain <= i_cfg.data;
                mao_pkg::CFG_VBUS_GAIN: r_cfg.vbus_gain <= i_cfg.data;
                mao_pkg::CFG_RUN_NEW:
                    r_cfg.coef_new[mao_pkg::GRP_RUN] <= i_cfg.data[mao_pkg::COEF_W-1:0];
                mao_pkg::CFG_RUN_OLD:
                    r_cfg.coef_old[mao_pkg::GRP_RUN] <= i_cfg.data[mao_pkg::COEF_W-1:0];
                mao_pkg::CFG_SLOW_NEW:
                    r_cfg.coef_new[mao_pkg::GRP_SLOW] <= i_cfg.data[mao_pkg::COEF_W-1:0];
                mao_pkg::CFG_SLOW_OLD:
                    r_cfg.coef_old[mao_pkg::GRP_SLOW] <= i_cfg.data[mao_pkg::COEF_W-1:0];
                mao_pkg::CFG_REF_NEW:
                    r_cfg.coef_new[mao_pkg::GRP_REF] <= i_cfg.data[mao_pkg::COEF_W-1:0];
                mao_pkg::CFG_REF_OLD:
                    r_cfg.coef_old[mao_pkg::GRP_REF] <= i_cfg.data[mao_pkg::COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mao_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    mao_back #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_cfg   (r_cfg),
        .o_res   (o_res)
    );

    // back end only pulls from a non-empty queue
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

    // once offsets are set, later results keep the flag
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(o_res.offsets_ready))
        else $error("offsets ready flag dropped");

    // a pop starts work, so no result can be presented on the very next edge
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !o_res.valid) |=> !o_res.valid)
        else $error("result appeared without processing time");

endmodule
